// ----- design/nnlr_pkg.sv -----
`timescale 1ns / 1ps

package nnlr_pkg;

   // Store geometry and label width.
   localparam int MAX_ROWS   = 256;
   localparam int MAX_COLS   = 256;
   localparam int LABEL_BITS = 8;

   localparam int ROW_BITS        = $clog2(MAX_ROWS);
   localparam int COL_BITS        = $clog2(MAX_COLS);
   localparam int LABEL_ADDR_BITS = ROW_BITS + COL_BITS;
   localparam int LABEL_DEPTH     = MAX_ROWS * MAX_COLS;

   // Field widths fixed by the channel and register definitions.
   localparam int DIM_BITS   = 9;
   localparam int COORD_BITS = 8;
   localparam int OUT_BITS   = 8;

   // Coordinate mapping tables, one per axis, sized for the larger axis.
   localparam int MAP_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int MAP_BITS  = $clog2(MAP_DEPTH);

   // Divider operands: 2*(S-1) and 2*(D-1).
   localparam int DIV_BITS     = DIM_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
   // Running quotient of the table sweep: up to MAP_DEPTH * MAP_DEPTH.
   localparam int Q_BITS = 2 * MAP_BITS + 1;

   // Queue between front and back.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SRC_HEIGHT = 2'd0,
      CSR_SRC_WIDTH  = 2'd1,
      CSR_DST_HEIGHT = 2'd2,
      CSR_DST_WIDTH  = 2'd3
   } csr_index_type;

   // Configured sizes, already clamped.
   typedef struct packed {
      logic [DIM_BITS-1:0] src_height;
      logic [DIM_BITS-1:0] src_width;
      logic [DIM_BITS-1:0] dst_height;
      logic [DIM_BITS-1:0] dst_width;
   } dims_type;

   // Table builder control for one axis.
   typedef struct packed {
      logic                start;
      logic [DIM_BITS-1:0] src_dim;
      logic [DIM_BITS-1:0] dst_dim;
   } axis_ctrl_type;

   // One classified item on its way from front to back.
   typedef struct packed {
      logic                       is_write;
      logic                       bad;
      logic [LABEL_ADDR_BITS-1:0] addr;
      logic [LABEL_BITS-1:0]      label;
   } queue_entry_type;

   // Register value as the block uses it: zero acts as one, large values saturate.
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] value,
                                                     input logic [DIM_BITS:0]   max_dim);
      logic [DIM_BITS-1:0] result;
      if (value == '0) begin
         result = DIM_BITS'(1);
      end else if ({1'b0, value} > max_dim) begin
         result = max_dim[DIM_BITS-1:0];
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

// ----- design/nnlr_req_if.sv -----
`timescale 1ns / 1ps

interface nnlr_req_if;
   logic                             valid;
   logic                             ready;
   logic                             mode;
   logic [nnlr_pkg::COORD_BITS-1:0] row;
   logic [nnlr_pkg::COORD_BITS-1:0] col;
   logic [nnlr_pkg::OUT_BITS-1:0]   label;

   modport source (output valid, output mode, output row, output col, output label,
                   input ready);
   modport sink (input valid, input mode, input row, input col, input label,
                 output ready);
endinterface

// ----- design/nnlr_rsp_if.sv -----
`timescale 1ns / 1ps

interface nnlr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [nnlr_pkg::OUT_BITS-1:0] out_label;
   logic                           bad_coord;

   modport source (output valid, output out_label, output bad_coord, input ready);
   modport sink (input valid, input out_label, input bad_coord, output ready);
endinterface

// ----- design/nearest_neighbor_label_resize.sv -----
`timescale 1ns / 1ps

// Channel    Direction  Handshake        Payload
// req_chan   in         valid / ready    mode, row, col, label
// rsp_chan   out        valid / ready    out_label, bad_coord
// csr        in         csr_we           csr_index, csr_wdata
//
// One item per cycle is accepted unless a table rebuild or a full queue holds requests off.
// After reset and after every register write the two coordinate tables are rebuilt:
// a start step, a divide and a 256-entry table sweep, during which no item is accepted.
// Label store not cleared; the user must read an entry only after it was written; unchecked.
// A stalled result holds in the output register while the queue keeps filling.

module nearest_neighbor_label_resize (
   input  logic                                clock,
   input  logic                                reset,
   nnlr_req_if.sink                            req_chan,
   nnlr_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [nnlr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [nnlr_pkg::DIM_BITS-1:0]       csr_wdata
);

   nnlr_pkg::dims_type                  dims_ff, dims_in;
   logic                                start_ff;
   nnlr_pkg::axis_ctrl_type             row_ctrl, col_ctrl;
   logic                                row_busy, col_busy;
   logic                                map_rd_en;
   logic [nnlr_pkg::MAP_BITS-1:0]       map_row_addr, map_col_addr;
   logic [nnlr_pkg::MAP_BITS-1:0]       map_row_data, map_col_data;
   logic                                push, pop, empty;
   nnlr_pkg::queue_entry_type           push_entry, head;
   logic [nnlr_pkg::QUEUE_CNT_BITS-1:0] queue_count;

   // Size registers, clamped as they are written.
   always_comb begin
      dims_in = dims_ff;
      if (csr_we) begin
         case (csr_index)
            nnlr_pkg::CSR_SRC_HEIGHT: dims_in.src_height =
               nnlr_pkg::clamp_dim(csr_wdata, (nnlr_pkg::DIM_BITS + 1)'(nnlr_pkg::MAX_ROWS));
            nnlr_pkg::CSR_SRC_WIDTH: dims_in.src_width =
               nnlr_pkg::clamp_dim(csr_wdata, (nnlr_pkg::DIM_BITS + 1)'(nnlr_pkg::MAX_COLS));
            nnlr_pkg::CSR_DST_HEIGHT: dims_in.dst_height =
               nnlr_pkg::clamp_dim(csr_wdata, (nnlr_pkg::DIM_BITS + 1)'(nnlr_pkg::MAX_ROWS));
            nnlr_pkg::CSR_DST_WIDTH: dims_in.dst_width =
               nnlr_pkg::clamp_dim(csr_wdata, (nnlr_pkg::DIM_BITS + 1)'(nnlr_pkg::MAX_COLS));
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff  <= {4{nnlr_pkg::DIM_BITS'(1)}};
         start_ff <= 1'b1;
      end else begin
         dims_ff  <= dims_in;
         start_ff <= csr_we;
      end
   end

   // Table rebuild requests, one builder per axis.
   always_comb begin
      row_ctrl.start   = start_ff;
      row_ctrl.src_dim = dims_ff.src_height;
      row_ctrl.dst_dim = dims_ff.dst_height;
      col_ctrl.start   = start_ff;
      col_ctrl.src_dim = dims_ff.src_width;
      col_ctrl.dst_dim = dims_ff.dst_width;
   end

   nnlr_axis u_row_axis (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (row_ctrl),
      .busy    (row_busy),
      .rd_en   (map_rd_en),
      .rd_addr (map_row_addr),
      .rd_data (map_row_data)
   );

   nnlr_axis u_col_axis (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (col_ctrl),
      .busy    (col_busy),
      .rd_en   (map_rd_en),
      .rd_addr (map_col_addr),
      .rd_data (map_col_data)
   );

   nnlr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .dims         (dims_ff),
      .busy         (row_busy || col_busy),
      .queue_count  (queue_count),
      .map_rd_en    (map_rd_en),
      .map_row_addr (map_row_addr),
      .map_col_addr (map_col_addr),
      .map_row_data (map_row_data),
      .map_col_data (map_col_data),
      .push         (push),
      .push_entry   (push_entry)
   );

   nnlr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .count      (queue_count)
   );

   nnlr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .empty    (empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- design/nnlr_ram.sv -----
`timescale 1ns / 1ps

module nnlr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port, one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- design/nnlr_axis.sv -----
`timescale 1ns / 1ps

module nnlr_axis (
   input  logic                          clock,
   input  logic                          reset,
   input  nnlr_pkg::axis_ctrl_type       ctrl,
   output logic                          busy,
   input  logic                          rd_en,
   input  logic [nnlr_pkg::MAP_BITS-1:0] rd_addr,
   output logic [nnlr_pkg::MAP_BITS-1:0] rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SWEEP
   } state_type;

   state_type                            state_ff, state_in;
   logic [nnlr_pkg::DIV_CNT_BITS-1:0]    div_cnt_ff, div_cnt_in;
   logic [nnlr_pkg::MAP_BITS:0]          idx_ff, idx_in;
   logic [nnlr_pkg::DIV_BITS-1:0]        den_ff, den_in;
   logic [nnlr_pkg::DIV_BITS-1:0]        dvd_ff, dvd_in;
   logic [nnlr_pkg::DIV_BITS-1:0]        rem_ff, rem_in;
   logic [nnlr_pkg::DIV_BITS-1:0]        qs_ff, qs_in;
   logic [nnlr_pkg::DIV_BITS-1:0]        r_ff, r_in;
   logic [nnlr_pkg::Q_BITS-1:0]          q_ff, q_in;
   logic [nnlr_pkg::DIM_BITS-1:0]        smax_ff, smax_in;
   logic                                 zero_ff, zero_in;

   logic [nnlr_pkg::DIV_BITS:0]          trial;
   logic [nnlr_pkg::DIV_BITS:0]          rsum;
   logic [nnlr_pkg::Q_BITS-1:0]          q_step;
   logic                                 tbl_we;
   logic [nnlr_pkg::MAP_BITS-1:0]        tbl_wdata;

   // Table entry for the current output index, clamped to the last source index.
   always_comb begin
      tbl_we = (state_ff == ST_SWEEP);
      if (zero_ff) begin
         tbl_wdata = '0;
      end else if (q_ff > nnlr_pkg::Q_BITS'(smax_ff)) begin
         tbl_wdata = nnlr_pkg::MAP_BITS'(smax_ff);
      end else begin
         tbl_wdata = q_ff[nnlr_pkg::MAP_BITS-1:0];
      end
   end

   // One restoring division step and one sweep step.
   always_comb begin
      trial  = {rem_ff, dvd_ff[nnlr_pkg::DIV_BITS-1]};
      rsum   = {1'b0, r_ff} + {1'b0, rem_ff};
      q_step = q_ff + nnlr_pkg::Q_BITS'(qs_ff);
   end

   // Sequencer: latch sizes, divide 2*(S-1) by 2*(D-1), then fill the table.
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      idx_in     = idx_ff;
      den_in     = den_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      qs_in      = qs_ff;
      r_in       = r_ff;
      q_in       = q_ff;
      smax_in    = smax_ff;
      zero_in    = zero_ff;
      if (ctrl.start) begin
         state_in   = ST_DIV;
         div_cnt_in = '0;
         den_in     = {ctrl.dst_dim - nnlr_pkg::DIM_BITS'(1), 1'b0};
         dvd_in     = {ctrl.src_dim - nnlr_pkg::DIM_BITS'(1), 1'b0};
         rem_in     = '0;
         qs_in      = '0;
         smax_in    = ctrl.src_dim - nnlr_pkg::DIM_BITS'(1);
         zero_in    = (ctrl.dst_dim <= nnlr_pkg::DIM_BITS'(1));
      end else begin
         case (state_ff)
            ST_IDLE: begin
            end
            ST_DIV: begin
               dvd_in     = {dvd_ff[nnlr_pkg::DIV_BITS-2:0], 1'b0};
               div_cnt_in = div_cnt_ff + nnlr_pkg::DIV_CNT_BITS'(1);
               if (trial >= {1'b0, den_ff}) begin
                  rem_in = nnlr_pkg::DIV_BITS'(trial - {1'b0, den_ff});
                  qs_in  = {qs_ff[nnlr_pkg::DIV_BITS-2:0], 1'b1};
               end else begin
                  rem_in = trial[nnlr_pkg::DIV_BITS-1:0];
                  qs_in  = {qs_ff[nnlr_pkg::DIV_BITS-2:0], 1'b0};
               end
               if (zero_ff || div_cnt_ff == nnlr_pkg::DIV_CNT_BITS'(nnlr_pkg::DIV_BITS - 1)) begin
                  state_in = ST_SWEEP;
                  idx_in   = '0;
                  q_in     = '0;
                  r_in     = {1'b0, den_ff[nnlr_pkg::DIV_BITS-1:1]};
               end
            end
            ST_SWEEP: begin
               idx_in = idx_ff + (nnlr_pkg::MAP_BITS + 1)'(1);
               if (rsum >= {1'b0, den_ff}) begin
                  r_in = nnlr_pkg::DIV_BITS'(rsum - {1'b0, den_ff});
                  q_in = q_step + nnlr_pkg::Q_BITS'(1);
               end else begin
                  r_in = rsum[nnlr_pkg::DIV_BITS-1:0];
                  q_in = q_step;
               end
               if (idx_ff == (nnlr_pkg::MAP_BITS + 1)'(nnlr_pkg::MAP_DEPTH - 1)) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      div_cnt_ff <= div_cnt_in;
      idx_ff     <= idx_in;
      den_ff     <= den_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      qs_ff      <= qs_in;
      r_ff       <= r_in;
      q_ff       <= q_in;
      smax_ff    <= smax_in;
      zero_ff    <= zero_in;
   end

   assign busy = ctrl.start || (state_ff != ST_IDLE);

   nnlr_ram #(
      .WIDTH (nnlr_pkg::MAP_BITS),
      .DEPTH (nnlr_pkg::MAP_DEPTH)
   ) u_table (
      .clock      (clock),
      .wr_en      (tbl_we),
      .wr_addr    (idx_ff[nnlr_pkg::MAP_BITS-1:0]),
      .wr_data    (tbl_wdata),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // A finished sweep has written every table entry.
   a_sweep_ends_full : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && !ctrl.start && state_in == ST_IDLE) |->
      (idx_ff == (nnlr_pkg::MAP_BITS + 1)'(nnlr_pkg::MAP_DEPTH - 1)))
      else $error("table sweep ended early");

endmodule

// ----- design/nnlr_front.sv -----
`timescale 1ns / 1ps

module nnlr_front (
   input  logic                                clock,
   input  logic                                reset,
   nnlr_req_if.sink                            req_chan,
   input  nnlr_pkg::dims_type                  dims,
   input  logic                                busy,
   input  logic [nnlr_pkg::QUEUE_CNT_BITS-1:0] queue_count,
   output logic                                map_rd_en,
   output logic [nnlr_pkg::MAP_BITS-1:0]       map_row_addr,
   output logic [nnlr_pkg::MAP_BITS-1:0]       map_col_addr,
   input  logic [nnlr_pkg::MAP_BITS-1:0]       map_row_data,
   input  logic [nnlr_pkg::MAP_BITS-1:0]       map_col_data,
   output logic                                push,
   output nnlr_pkg::queue_entry_type           push_entry
);

   logic                                accept;
   logic                                bad;
   logic [nnlr_pkg::QUEUE_CNT_BITS:0]   pending;
   logic [nnlr_pkg::DIM_BITS-1:0]       row_ext, col_ext;

   logic                                f1_valid_ff, f1_valid_in;
   logic                                f1_write_ff;
   logic                                f1_bad_ff;
   logic [nnlr_pkg::COORD_BITS-1:0]     f1_row_ff, f1_col_ff;
   logic [nnlr_pkg::LABEL_BITS-1:0]     f1_label_ff;

   // Space is reserved for the item already in the lookup stage.
   assign pending        = {1'b0, queue_count} + (nnlr_pkg::QUEUE_CNT_BITS + 1)'(f1_valid_ff);
   assign req_chan.ready = !busy && (pending < (nnlr_pkg::QUEUE_CNT_BITS + 1)'(nnlr_pkg::QUEUE_DEPTH));
   assign accept         = req_chan.valid && req_chan.ready;

   // Range check against the source size for writes and the output size for reads.
   always_comb begin
      row_ext = nnlr_pkg::DIM_BITS'(req_chan.row);
      col_ext = nnlr_pkg::DIM_BITS'(req_chan.col);
      if (req_chan.mode) begin
         bad = (row_ext >= dims.dst_height) || (col_ext >= dims.dst_width);
      end else begin
         bad = (row_ext >= dims.src_height) || (col_ext >= dims.src_width);
      end
   end

   // Look up both mapping tables for the accepted item.
   assign map_rd_en    = accept;
   assign map_row_addr = nnlr_pkg::MAP_BITS'(req_chan.row);
   assign map_col_addr = nnlr_pkg::MAP_BITS'(req_chan.col);

   assign f1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
      if (accept) begin
         f1_write_ff <= !req_chan.mode;
         f1_bad_ff   <= bad;
         f1_row_ff   <= req_chan.row;
         f1_col_ff   <= req_chan.col;
         f1_label_ff <= nnlr_pkg::LABEL_BITS'(req_chan.label);
      end
   end

   // Writes go to their own coordinate, reads to the mapped source coordinate.
   always_comb begin
      push                = f1_valid_ff;
      push_entry.is_write = f1_write_ff;
      push_entry.bad      = f1_bad_ff;
      push_entry.label    = f1_label_ff;
      if (f1_write_ff) begin
         push_entry.addr = {nnlr_pkg::ROW_BITS'(f1_row_ff), nnlr_pkg::COL_BITS'(f1_col_ff)};
      end else begin
         push_entry.addr = {nnlr_pkg::ROW_BITS'(map_row_data),
                            nnlr_pkg::COL_BITS'(map_col_data)};
      end
   end

   // No item enters while a mapping table is being rebuilt.
   a_no_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |-> !busy)
      else $error("item accepted during table rebuild");

endmodule

// ----- design/nnlr_queue.sv -----
`timescale 1ns / 1ps

module nnlr_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  nnlr_pkg::queue_entry_type           push_entry,
   input  logic                                pop,
   output nnlr_pkg::queue_entry_type           head,
   output logic                                empty,
   output logic [nnlr_pkg::QUEUE_CNT_BITS-1:0] count
);

   nnlr_pkg::queue_entry_type           slot_ff [nnlr_pkg::QUEUE_DEPTH];
   logic [nnlr_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [nnlr_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [nnlr_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + nnlr_pkg::QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + nnlr_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + nnlr_pkg::QUEUE_CNT_BITS'(push) - nnlr_pkg::QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff < nnlr_pkg::QUEUE_CNT_BITS'(nnlr_pkg::QUEUE_DEPTH)))
      else $error("queue overflow");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue underflow");

endmodule

// ----- design/nnlr_back.sv -----
`timescale 1ns / 1ps

module nnlr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  nnlr_pkg::queue_entry_type head,
   input  logic                      empty,
   output logic                      pop,
   nnlr_rsp_if.source                rsp_chan
);

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_bad_ff;
   logic                            good_write;
   logic                            good_read;
   logic [nnlr_pkg::LABEL_BITS-1:0] rd_data;

   // Take the next item once the result register is free or being emptied.
   assign pop        = !empty && (!rsp_valid_ff || rsp_chan.ready);
   assign good_write = pop && head.is_write && !head.bad;
   assign good_read  = pop && !head.is_write && !head.bad;

   // Every item but a good write leaves one result.
   always_comb begin
      if (pop) begin
         rsp_valid_in = !(head.is_write && !head.bad);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         rsp_bad_ff <= head.bad;
      end
   end

   // Source label store; read data holds while the result waits.
   nnlr_ram #(
      .WIDTH (nnlr_pkg::LABEL_BITS),
      .DEPTH (nnlr_pkg::LABEL_DEPTH)
   ) u_labels (
      .clock      (clock),
      .wr_en      (good_write),
      .wr_addr    (head.addr),
      .wr_data    (head.label),
      .rd_en      (good_read),
      .rd_addr    (head.addr),
      .rd_data_ff (rd_data)
   );

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.bad_coord = rsp_bad_ff;
   assign rsp_chan.out_label = rsp_bad_ff ? '0 : nnlr_pkg::OUT_BITS'(rd_data);

   // A good write leaves the result register empty.
   a_write_no_result : assert property (@(posedge clock) disable iff (reset)
      good_write |=> !rsp_valid_ff)
      else $error("result shown for a stored label");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   // Expected result of one item.
   typedef struct {
      logic [nnlr_pkg::OUT_BITS-1:0] out_label;
      logic                          bad_coord;
   } label_result_type;

   localparam int CYCLE_LIMIT = 400000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_we = 1'b0;
   logic [nnlr_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [nnlr_pkg::DIM_BITS-1:0]       csr_wdata = '0;

   nnlr_req_if req_bus ();
   nnlr_rsp_if rsp_bus ();

   nearest_neighbor_label_resize i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block's sizes and label store.
   int unsigned                     src_h = 1, src_w = 1, dst_h = 1, dst_w = 1;
   logic [nnlr_pkg::LABEL_BITS-1:0] shadow_labels [nnlr_pkg::LABEL_DEPTH];
   bit                              shadow_written [nnlr_pkg::LABEL_DEPTH];
   label_result_type                pending_results [$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  idling_on = 1'b1;
   int  rsp_stall = 0;

   always #4 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode  = 1'b0;
      req_bus.row   = '0;
      req_bus.col   = '0;
      req_bus.label = '0;
      rsp_bus.ready = 1'b0;
   end

   // Hard stop if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Zero acts as one; values above the store size saturate.
   function automatic int unsigned clamp_size(int unsigned value, int unsigned max_dim);
      int unsigned v;
      v = value & 32'h1FF;
      if (v == 0) return 1;
      if (v > max_dim) return max_dim;
      return v;
   endfunction

   // Corner-aligned nearest index along one axis, ties rounded up.
   function automatic int unsigned nearest_index(int unsigned o, int unsigned s,
                                                 int unsigned d);
      int unsigned q;
      if (d <= 1) return 0;
      q = (2 * o * (s - 1) + (d - 1)) / (2 * (d - 1));
      if (q >= s) q = s - 1;
      return q;
   endfunction

   // Works out the result, if any, of one accepted item and updates the store.
   function automatic void predict_label(logic mode, int unsigned row, int unsigned col,
                                         logic [nnlr_pkg::LABEL_BITS-1:0] label);
      label_result_type r;
      int unsigned      addr;
      r.out_label = '0;
      r.bad_coord = 1'b0;
      if (!mode) begin
         if (row >= src_h || col >= src_w) begin
            r.bad_coord = 1'b1;
            pending_results = {pending_results, r};
         end else begin
            addr = row * nnlr_pkg::MAX_COLS + col;
            shadow_labels[addr]  = label;
            shadow_written[addr] = 1'b1;
         end
      end else begin
         if (row >= dst_h || col >= dst_w) begin
            r.bad_coord = 1'b1;
         end else begin
            addr = nearest_index(row, src_h, dst_h) * nnlr_pkg::MAX_COLS
                   + nearest_index(col, src_w, dst_w);
            r.out_label = shadow_labels[addr];
         end
         pending_results = {pending_results, r};
      end
   endfunction

   // Result side: compare each result as it is taken, then draw a stall.
   always @(posedge clock) begin
      label_result_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result: label %0d bad %0b",
                        rsp_bus.out_label, rsp_bus.bad_coord);
         end else begin
            exp_r = pending_results.pop_front();
            if (exp_r.out_label !== rsp_bus.out_label ||
                exp_r.bad_coord !== rsp_bus.bad_coord) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected label %0d bad %0b, got label %0d bad %0b",
                           exp_r.out_label, exp_r.bad_coord,
                           rsp_bus.out_label, rsp_bus.bad_coord);
            end
         end
         rsp_stall = idling_on ? $urandom_range(0, 9) : 0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Sends one item; called at a falling edge and returns at one.
   task automatic send_item(logic mode, int unsigned row, int unsigned col,
                            logic [nnlr_pkg::LABEL_BITS-1:0] label);
      int gap;
      gap = idling_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode  <= mode;
      req_bus.row   <= row[nnlr_pkg::COORD_BITS-1:0];
      req_bus.col   <= col[nnlr_pkg::COORD_BITS-1:0];
      req_bus.label <= label;
      do @(posedge clock); while (!req_bus.ready);
      predict_label(mode, row[7:0], col[7:0], label);
      @(negedge clock);
   endtask

   // Reads an output pixel, first storing the source entry it maps to if needed.
   task automatic read_pixel(int unsigned row, int unsigned col);
      int unsigned sr, sc;
      if (row < dst_h && col < dst_w) begin
         sr = nearest_index(row, src_h, dst_h);
         sc = nearest_index(col, src_w, dst_w);
         if (!shadow_written[sr * nnlr_pkg::MAX_COLS + sc])
            send_item(1'b0, sr, sc, nnlr_pkg::LABEL_BITS'($urandom_range(0, 255)));
      end
      send_item(1'b1, row, col, nnlr_pkg::LABEL_BITS'($urandom_range(0, 255)));
   endtask

   // Waits until no results are outstanding, then writes one register.
   task automatic write_size(nnlr_pkg::csr_index_type idx, int unsigned value);
      req_bus.valid <= 1'b0;
      @(negedge clock);
      wait (pending_results.size() == 0);
      repeat (20) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[nnlr_pkg::DIM_BITS-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         nnlr_pkg::CSR_SRC_HEIGHT: src_h = clamp_size(value, nnlr_pkg::MAX_ROWS);
         nnlr_pkg::CSR_SRC_WIDTH:  src_w = clamp_size(value, nnlr_pkg::MAX_COLS);
         nnlr_pkg::CSR_DST_HEIGHT: dst_h = clamp_size(value, nnlr_pkg::MAX_ROWS);
         default:                  dst_w = clamp_size(value, nnlr_pkg::MAX_COLS);
      endcase
   endtask

   task automatic set_sizes(int unsigned sh, int unsigned sw, int unsigned dh,
                            int unsigned dw);
      write_size(nnlr_pkg::CSR_SRC_HEIGHT, sh);
      write_size(nnlr_pkg::CSR_SRC_WIDTH, sw);
      write_size(nnlr_pkg::CSR_DST_HEIGHT, dh);
      write_size(nnlr_pkg::CSR_DST_WIDTH, dw);
   endtask

   // Reset sizes of one: single pixel, and everything else out of range.
   task automatic test_reset_sizes();
      send_item(1'b0, 0, 0, 8'hA5);
      send_item(1'b1, 0, 0, 8'h00);
      send_item(1'b1, 1, 0, 8'h00);
      send_item(1'b0, 0, 1, 8'h11);
   endtask

   // Largest sizes, store corners and extreme labels.
   task automatic test_full_size_corners();
      set_sizes(256, 256, 256, 256);
      send_item(1'b0, 0, 0, 8'h00);
      send_item(1'b0, 255, 255, 8'hFF);
      send_item(1'b0, 0, 255, 8'h5A);
      send_item(1'b0, 255, 0, 8'hC3);
      send_item(1'b1, 0, 0, 8'hFF);
      send_item(1'b1, 255, 255, 8'h00);
      send_item(1'b1, 0, 255, 8'h00);
      send_item(1'b1, 255, 0, 8'h00);
   endtask

   // Zero and oversized register values, and output sizes of one.
   task automatic test_size_clamp();
      set_sizes(0, 511, 1, 0);
      send_item(1'b0, 0, 255, 8'h3C);
      send_item(1'b0, 1, 0, 8'h01);
      send_item(1'b1, 0, 0, 8'h00);
      send_item(1'b1, 0, 1, 8'h00);
      set_sizes(3, 3, 2, 5);
      read_pixel(1, 2);
      read_pixel(1, 4);
      read_pixel(0, 1);
      send_item(1'b0, 3, 0, 8'h77);
      send_item(1'b1, 2, 0, 8'h00);
   endtask

   // Phases of random items under varied sizes.
   task automatic test_random_resize();
      int unsigned sh, sw, dh, dw, pick;
      for (int phase = 0; phase < 12; phase++) begin
         idling_on = (phase % 4) != 3;
         pick = $urandom_range(0, 9);
         sh = (pick == 0) ? 256 : $urandom_range(1, 16);
         sw = (pick == 1) ? 256 : $urandom_range(1, 16);
         dh = (pick == 2) ? 256 : $urandom_range(1, 32);
         dw = (pick == 3) ? 256 : $urandom_range(1, 32);
         if (pick == 4) begin
            sh = 0;
            dw = 300 + $urandom_range(0, 211);
         end
         set_sizes(sh, sw, dh, dw);
         for (int n = 0; n < 55; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 4) begin
               send_item(1'b0, $urandom_range(0, src_h - 1), $urandom_range(0, src_w - 1),
                         nnlr_pkg::LABEL_BITS'($urandom_range(0, 255)));
            end else if (pick == 4) begin
               send_item(1'b0, $urandom_range(0, 255), $urandom_range(0, 255),
                         nnlr_pkg::LABEL_BITS'($urandom_range(0, 255)));
            end else if (pick == 5) begin
               read_pixel($urandom_range(0, 255), $urandom_range(0, 255));
            end else begin
               read_pixel($urandom_range(0, dst_h - 1), $urandom_range(0, dst_w - 1));
            end
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_sizes();
      test_full_size_corners();
      test_size_clamp();
      test_random_resize();
      req_bus.valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
